### design/itda_pkg.sv
// shared constants, types and helper functions for the integer to decimal text converter
package itda_pkg;

    localparam int INPUT_BITS = 32;

    // decimal digits needed for the largest magnitude, 2^(INPUT_BITS-1)
    localparam int DIGITS = ((INPUT_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS = DIGITS * 4;
    localparam int IDX_W = $clog2(DIGITS);

    // magnitude bits handled per pipeline stage
    localparam int CHUNK = 8;
    localparam int NSTAGES = (INPUT_BITS + CHUNK - 1) / CHUNK;
    localparam int PAD_BITS = NSTAGES * CHUNK;

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef logic [BCD_BITS-1:0] bcd_t;
    typedef logic [PAD_BITS-1:0] mag_t;
    typedef logic [IDX_W-1:0] idx_t;

    // shift-and-add-3 over one chunk of magnitude bits, most significant first
    function automatic bcd_t dabble_chunk(input bcd_t bcd_in, input logic [CHUNK-1:0] bits);
        bcd_t b;
        b = bcd_in;
        for (int s = 0; s < CHUNK; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_BITS-2:0], bits[CHUNK-1-s]};
        end
        return b;
    endfunction

    // position of the most significant nonzero digit, zero when all digits are zero
    function automatic idx_t lead_digit(input bcd_t bcd);
        idx_t idx;
        idx = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd[d*4 +: 4] != 4'd0)
            begin
                idx = idx_t'(d);
            end
        end
        return idx;
    endfunction

endpackage

### design/int_to_decimal_ascii.sv
// integer to decimal ascii converter: binary-to-bcd pipeline feeding a character serializer
//
// usage: drive value and raise start; the word is taken at a rising edge where start is
// high and busy is low. the text of the number comes out one ascii character per cycle,
// most significant first, on char_code with char_valid high; a leading '-' marks a
// negative number, zero gives a single '0', and last_char flags the final character.
// a taken word passes one negate stage, four shift-and-add-3 stages of 8 bits, one
// leading-digit stage, the serializer load and the output register before its first
// character appears. the characters of one number leave in consecutive cycles and the
// next number's text can follow the last character with no gap.
// throughput: the single character output sets the rate, one character per cycle, and a
// number is 1 to 11 characters (sign plus up to ten digits); busy rises while the
// serializer is still spelling out an earlier number and a finished word waits in the
// leading-digit stage, and the whole pipeline holds until the serializer takes it.
// the receiver cannot stall: every character is shown for exactly one cycle.
// reset clears all valid bits and the serializer's active and sign flags; no character is
// produced until a word is taken after reset.
module int_to_decimal_ascii (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [itda_pkg::INPUT_BITS-1:0] value,
    output logic                           char_valid,
    output logic [itda_pkg::CHAR_W-1:0]    char_code,
    output logic                           last_char
);
    import itda_pkg::*;

    // pipeline stages: 0 holds sign and magnitude, 1..NSTAGES hold partial bcd
    logic [NSTAGES:0] v_reg;
    logic             neg_reg [0:NSTAGES];
    mag_t             mag_reg [0:NSTAGES];
    bcd_t             bcd_reg [0:NSTAGES];

    // leading digit stage
    logic lz_v_reg;
    logic lz_neg_reg;
    bcd_t lz_bcd_reg;
    idx_t lz_idx_reg;

    // serializer
    logic ser_active_reg, ser_active_next;
    logic ser_sign_reg, ser_sign_next;
    idx_t ser_idx_reg, ser_idx_next;
    bcd_t ser_bcd_reg, ser_bcd_next;

    // output register
    logic              char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0] char_code_reg, char_code_next;
    logic              last_char_reg, last_char_next;

    logic ser_last_now;
    logic accept_ser;
    logic advance;
    logic [INPUT_BITS-1:0] in_mag;

    assign ser_last_now = ser_active_reg && !ser_sign_reg && (ser_idx_reg == '0);
    assign accept_ser = !ser_active_reg || ser_last_now;
    // the whole pipeline moves together; it freezes only when a finished word waits
    assign advance = !lz_v_reg || accept_ser;
    assign busy = !advance;

    assign in_mag = value[INPUT_BITS-1] ? (~value + 1'b1) : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            lz_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NSTAGES-1:0], start};
            lz_v_reg <= v_reg[NSTAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg_reg[0] <= value[INPUT_BITS-1];
            mag_reg[0] <= mag_t'(in_mag);
            bcd_reg[0] <= '0;
            for (int k = 1; k <= NSTAGES; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
                mag_reg[k] <= mag_reg[k-1];
                bcd_reg[k] <= dabble_chunk(bcd_reg[k-1],
                                           mag_reg[k-1][PAD_BITS-1-CHUNK*(k-1) -: CHUNK]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lz_neg_reg <= neg_reg[NSTAGES];
            lz_bcd_reg <= bcd_reg[NSTAGES];
            lz_idx_reg <= lead_digit(bcd_reg[NSTAGES]);
        end
    end

    // serializer: sign first, then digits from the leading one down
    always_comb
    begin
        ser_active_next = ser_active_reg;
        ser_sign_next = ser_sign_reg;
        ser_idx_next = ser_idx_reg;
        ser_bcd_next = ser_bcd_reg;
        char_valid_next = 1'b0;
        char_code_next = CHAR_ZERO;
        last_char_next = 1'b0;

        if (ser_active_reg)
        begin
            char_valid_next = 1'b1;
            if (ser_sign_reg)
            begin
                char_code_next = CHAR_MINUS;
                ser_sign_next = 1'b0;
            end
            else
            begin
                char_code_next = CHAR_ZERO + {3'b000, ser_bcd_reg[ser_idx_reg*4 +: 4]};
                last_char_next = ser_last_now;
                if (ser_last_now)
                begin
                    ser_active_next = 1'b0;
                end
                else
                begin
                    ser_idx_next = ser_idx_reg - 1'b1;
                end
            end
        end

        if (accept_ser && lz_v_reg)
        begin
            ser_active_next = 1'b1;
            ser_sign_next = lz_neg_reg;
            ser_idx_next = lz_idx_reg;
            ser_bcd_next = lz_bcd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_active_reg <= 1'b0;
            ser_sign_reg <= 1'b0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            ser_active_reg <= ser_active_next;
            ser_sign_reg <= ser_sign_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_idx_reg <= ser_idx_next;
        ser_bcd_reg <= ser_bcd_next;
        char_code_reg <= char_code_next;
        last_char_reg <= last_char_next;
    end

    assign char_valid = char_valid_reg;
    assign char_code = char_code_reg;
    assign last_char = last_char_reg;

    // a minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_code == CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last character");

    // digits follow a minus sign in the very next cycle
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_code == CHAR_MINUS) |=> (char_valid && char_code != CHAR_MINUS))
        else $error("no digit right after minus sign");

    // a pending sign only exists inside an active word
    a_sign_active: assert property (@(posedge clk) disable iff (!rst_n)
        ser_sign_reg |-> ser_active_reg)
        else $error("sign pending with serializer idle");

    // an accepted word always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> v_reg[0])
        else $error("accepted word lost at pipeline entry");

endmodule

### bench/tb_int_to_decimal_ascii.sv
// testbench for the integer to decimal ascii converter: directed and random words, checked per character
module tb_int_to_decimal_ascii;
    import itda_pkg::*;

    typedef logic signed [INPUT_BITS-1:0] word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    class digit_scoreboard;
        text_char_t pending_chars[$];
        int         mismatches;
        int         chars_checked;
        int         words_noted;
        int         negatives;
        int         zeros;

        function new();
            mismatches    = 0;
            chars_checked = 0;
            words_noted   = 0;
            negatives     = 0;
            zeros         = 0;
        endfunction

        // decimal text of one word, sign first, most significant digit next
        function void note_word(word_t w);
            logic [INPUT_BITS:0]  mag;
            logic [CHAR_W-1:0]    digits[$];
            text_char_t           tc;
            logic                 neg;
            begin
                neg = w[INPUT_BITS-1];
                // one extra bit so the most negative word has room for its magnitude
                mag = neg ? (~{1'b1, w} + 1'b1) : {1'b0, w};
                words_noted++;
                if (neg)
                begin
                    negatives++;
                end
                if (mag == 0)
                begin
                    zeros++;
                    digits.push_front(CHAR_ZERO);
                end
                while (mag != 0)
                begin
                    digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
                    mag = mag / 10;
                end
                if (neg)
                begin
                    digits.push_front(CHAR_MINUS);
                end
                foreach (digits[i])
                begin
                    tc.code = digits[i];
                    tc.last = (i == digits.size() - 1);
                    pending_chars.push_back(tc);
                end
            end
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at char %0d: %s", chars_checked, what);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_char_t exp_c;
            begin
                if (pending_chars.size() == 0)
                begin
                    report($sformatf("unexpected char code %h last %b", code, last));
                end
                else
                begin
                    exp_c = pending_chars.pop_front();
                    if (code !== exp_c.code)
                    begin
                        report($sformatf("char_code expected %h got %h", exp_c.code, code));
                    end
                    if (last !== exp_c.last)
                    begin
                        report($sformatf("last_char expected %b got %b", exp_c.last, last));
                    end
                end
                chars_checked++;
            end
        endfunction

        function void drain_check();
            if (pending_chars.size() != 0)
            begin
                report($sformatf("%0d chars never arrived", pending_chars.size()));
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    word_t             value;
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    digit_scoreboard sb;

    int_to_decimal_ascii u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // outputs sampled at the rising edge, before the design updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_word(value);
            end
            if (char_valid)
            begin
                sb.check_char(char_code, last_char);
            end
        end
    end

    task automatic idle_cycle();
        @(negedge clk);
        start = 1'b0;
        value = word_t'($urandom);
    endtask

    // hold the word until the converter takes it
    task automatic send_word(word_t w, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            idle_cycle();
        end
        @(negedge clk);
        start = 1'b1;
        value = w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    function automatic word_t random_word();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        int              nd;
        int              pick;
        logic            neg;
        begin
            pick = $urandom_range(99);
            neg  = 1'($urandom_range(1));
            if (pick < 40)
            begin
                return word_t'($urandom);
            end
            nd = $urandom_range(10, 1);
            lo = 1;
            for (int i = 1; i < nd; i++)
            begin
                lo = lo * 10;
            end
            if (pick < 90)
            begin
                // random digit count so short texts show up as often as long ones
                hi = lo * 10 - 1;
                if (hi > (64'd1 << (INPUT_BITS - 1)) - (neg ? 0 : 1))
                begin
                    hi = (64'd1 << (INPUT_BITS - 1)) - (neg ? 0 : 1);
                end
                mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
            end
            else
            begin
                // powers of ten and their neighbors
                mag = lo + $urandom_range(2) - 1;
            end
            return neg ? word_t'(-longint'(mag)) : word_t'(mag);
        end
    endfunction

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        word_t directed[$];
        int    idle_pcts[3];
        int    wait_cycles;

        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        value     = '0;
        idle_pcts = '{0, 60, 10};
        directed  = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999999999, 1000000000,
                      -999999999, -1000000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                      32'sh55555555, 32'shAAAAAAAA, 12345, -6789, 5, 0};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            send_word(directed[i], (i % 4 == 3) ? 60 : 0);
        end

        foreach (idle_pcts[p])
        begin
            repeat (152)
            begin
                send_word(random_word(), idle_pcts[p]);
            end
        end
        idle_cycle();

        wait_cycles = 0;
        while (sb.pending_chars.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        // room for any stray chars after the last expected one
        repeat (20) @(posedge clk);
        sb.drain_check();

        $display("converted %0d words (%0d negative, %0d zero), %0d chars checked",
                 sb.words_noted, sb.negatives, sb.zeros, sb.chars_checked);
        $display("idle settings 0, 60 and 10 percent on the sender; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
